// ----- hw/rtl/dbsb_pkg.sv -----
// ============================================================================
// dbsb_pkg
// Types and constants shared by the button debounce and status blinker block.
// ============================================================================
package dbsb_pkg;

    // opcodes of a command beat
    localparam logic OP_POLL = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // error codes on a result beat
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_INVALID_MODE = 4'd15;

    // configuration register indexes
    localparam logic CFG_DEBOUNCE_SAMPLES = 1'b0;
    localparam logic CFG_ACTIVE_LEVEL     = 1'b1;

    localparam logic [7:0] DEBOUNCE_SAMPLES_RST = 8'd5;
    localparam logic       ACTIVE_LEVEL_RST     = 1'b0;

    // indicator modes
    typedef enum logic [2:0] {
        MODE_BOOTING   = 3'd0,
        MODE_READY     = 3'd1,
        MODE_EXECUTING = 3'd2,
        MODE_DEGRADED  = 3'd3,
        MODE_FATAL     = 3'd4
    } mode_t;

    // blink timing, all patterns repeat within one 2000 ms frame
    localparam int FRAME_MS        = 2000;
    localparam int PHASE_W         = 11;
    localparam int PHASE_LSB       = 4;   // FRAME_MS = 125 * 2**PHASE_LSB
    localparam int FOLD_MOD        = FRAME_MS / (2 ** PHASE_LSB);
    localparam int FOLD_SUM_W      = 13;
    localparam int BOOT_PERIOD_MS  = 1000;
    localparam int BOOT_ON_MS      = 250;
    localparam int EXEC_PERIOD_MS  = 200;
    localparam int EXEC_ON_MS      = 100;
    localparam int EXEC_SLOTS      = FRAME_MS / EXEC_PERIOD_MS;
    localparam int FATAL_PERIOD_MS = 500;
    localparam int FATAL_ON_MS     = 250;
    localparam int FATAL_SLOTS     = FRAME_MS / FATAL_PERIOD_MS;
    localparam int DEGR_ON_MS      = 250;
    localparam int DEGR_SECOND_LO  = 500;
    localparam int DEGR_SECOND_HI  = 750;

    // command beat
    typedef struct packed {
        logic        opcode;
        logic        stop_request;
        logic [3:0]  read_error_code;
        logic        confirm_level;
        logic        cancel_level;
        logic [31:0] stamp_ms;
        logic [2:0]  new_mode;
    } cmd_beat_t;

    // result beat
    typedef struct packed {
        logic       keep_running;
        logic       confirm_press;
        logic       cancel_press;
        logic       led_valid;
        logic       led_on;
        logic [3:0] error_code;
        logic       fault_seen;
    } res_beat_t;

    // per-button debouncer state
    typedef struct packed {
        logic       candidate;
        logic [7:0] count;
        logic       stable;
    } db_state_t;

    typedef struct packed {
        db_state_t st;
        logic      press;
    } db_result_t;

endpackage

// ----- hw/rtl/dbsb_stream_if.sv -----
// ============================================================================
// dbsb_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ============================================================================
interface dbsb_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        input  ready,
        output data
    );

    modport sink (
        input  valid,
        output ready,
        input  data
    );

endinterface

// ----- hw/rtl/dual_button_debounce_status_blinker.sv -----
// ============================================================================
// dual_button_debounce_status_blinker
// Two counter debouncers, a sticky read fault and a mode driven status LED.
// ============================================================================
// two register stages: a command beat is taken into the input stage, and its
// result beat is registered in the result stage when that stage can advance
// throughput: one command beat per cycle unless a result beat stalls the pipe
// the input stage folds the time stamp, the second stage updates the block state
// reset: debounce samples 5, active level low, debouncers cleared,
// mode booting, fault flag cleared, both pipeline stages empty
module dual_button_debounce_status_blinker
    import dbsb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata,
    dbsb_stream_if.sink         cmd,
    dbsb_stream_if.source       res
);

    // one debouncer step on a pressed/not pressed sample
    function automatic db_result_t db_step(db_state_t cur, logic sample, logic [7:0] samples);
        db_result_t r;
        logic [7:0] cnt;
        r       = '{st: cur, press: 1'b0};
        cnt     = cur.count;
        if (sample != cur.candidate)
        begin
            r.st.candidate = sample;
            r.st.count     = 8'd1;
        end
        else
        begin
            if (cnt < samples)
            begin
                cnt = cnt + 8'd1;
            end
            r.st.count = cnt;
            if (cnt == samples && cur.stable != sample)
            begin
                r.st.stable = sample;
                r.press     = sample;
            end
        end
        return r;
    endfunction

    // LED drive for a mode at a phase inside the 2000 ms frame
    function automatic logic blink_on(mode_t mode, logic [PHASE_W-1:0] pos);
        logic exec_hit;
        logic fatal_hit;
        logic on;
        exec_hit  = 1'b0;
        fatal_hit = 1'b0;
        for (int k = 0; k < EXEC_SLOTS; k++)
        begin
            if (pos >= PHASE_W'(k * EXEC_PERIOD_MS) &&
                pos <  PHASE_W'(k * EXEC_PERIOD_MS + EXEC_ON_MS))
            begin
                exec_hit = 1'b1;
            end
        end
        for (int k = 0; k < FATAL_SLOTS; k++)
        begin
            if (pos >= PHASE_W'(k * FATAL_PERIOD_MS) &&
                pos <  PHASE_W'(k * FATAL_PERIOD_MS + FATAL_ON_MS))
            begin
                fatal_hit = 1'b1;
            end
        end
        unique case (mode)
            MODE_READY:     on = 1'b1;
            MODE_BOOTING:   on = (pos < PHASE_W'(BOOT_ON_MS)) ||
                                 (pos >= PHASE_W'(BOOT_PERIOD_MS) &&
                                  pos <  PHASE_W'(BOOT_PERIOD_MS + BOOT_ON_MS));
            MODE_EXECUTING: on = exec_hit;
            MODE_DEGRADED:  on = (pos < PHASE_W'(DEGR_ON_MS)) ||
                                 (pos >= PHASE_W'(DEGR_SECOND_LO) &&
                                  pos <  PHASE_W'(DEGR_SECOND_HI));
            MODE_FATAL:     on = fatal_hit;
            default:        on = 1'b0;
        endcase
        return on;
    endfunction

    // configuration registers
    logic [7:0] samples_reg;
    logic       active_level_reg;

    // input stage
    logic                      v1_reg;
    cmd_beat_t                 cmd_reg;
    logic [FOLD_SUM_W-1:0]     fold_reg;
    logic [FOLD_SUM_W-1:0]     fold_next;

    // block state
    db_state_t confirm_reg;
    db_state_t cancel_reg;
    mode_t     mode_reg;
    logic      fault_reg;

    // result stage
    logic      out_valid_reg;
    res_beat_t out_reg;

    // next values from the second stage
    db_state_t  confirm_next;
    db_state_t  cancel_next;
    mode_t      mode_next;
    logic       fault_next;
    res_beat_t  out_next;
    db_result_t confirm_res;
    db_result_t cancel_res;

    // phase reduction
    logic [7:0]         fold2;
    logic [6:0]         frame_hi;
    logic [PHASE_W-1:0] phase;

    logic advance;
    logic s1_fire;
    logic in_fire;

    // pipeline handshake
    assign advance   = !out_valid_reg || res.ready;
    assign s1_fire   = v1_reg && advance;
    assign cmd.ready = !v1_reg || advance;
    assign in_fire   = cmd.valid && cmd.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    // first fold of (stamp_ms >> 4) mod 125, 128**k mod 125 = 3**k
    assign fold_next = FOLD_SUM_W'(cmd.data.stamp_ms[10:4])
                     + FOLD_SUM_W'(cmd.data.stamp_ms[17:11]) * FOLD_SUM_W'(3)
                     + FOLD_SUM_W'(cmd.data.stamp_ms[24:18]) * FOLD_SUM_W'(9)
                     + FOLD_SUM_W'(cmd.data.stamp_ms[31:25]) * FOLD_SUM_W'(27);

    // second fold and final correction give the phase in the frame
    always_comb
    begin
        fold2 = 8'(fold_reg[6:0]) + 8'(fold_reg[FOLD_SUM_W-1:7]) * 8'd3;
        if (fold2 >= 8'(FOLD_MOD))
        begin
            frame_hi = 7'(fold2 - 8'(FOLD_MOD));
        end
        else
        begin
            frame_hi = fold2[6:0];
        end
        phase = {frame_hi, cmd_reg.stamp_ms[PHASE_LSB-1:0]};
    end

    // command decode, debouncing and LED drive
    always_comb
    begin
        confirm_next = confirm_reg;
        cancel_next  = cancel_reg;
        mode_next    = mode_reg;
        fault_next   = fault_reg;
        out_next     = '0;
        confirm_res  = db_step(confirm_reg, cmd_reg.confirm_level == active_level_reg,
                               samples_reg);
        cancel_res   = db_step(cancel_reg, cmd_reg.cancel_level == active_level_reg,
                               samples_reg);
        if (cmd_reg.opcode == OP_SET)
        begin
            if (cmd_reg.new_mode > MODE_FATAL)
            begin
                out_next.error_code = ERR_INVALID_MODE;
            end
            else
            begin
                mode_next = mode_t'(cmd_reg.new_mode);
            end
        end
        else if (!cmd_reg.stop_request)
        begin
            out_next.keep_running = 1'b1;
            if (cmd_reg.read_error_code != ERR_NONE)
            begin
                fault_next          = 1'b1;
                mode_next           = MODE_FATAL;
                out_next.error_code = cmd_reg.read_error_code;
            end
            else
            begin
                confirm_next           = confirm_res.st;
                cancel_next            = cancel_res.st;
                out_next.confirm_press = confirm_res.press;
                out_next.cancel_press  = cancel_res.press;
            end
            out_next.led_valid = 1'b1;
            out_next.led_on    = blink_on(mode_next, phase);
        end
        out_next.fault_seen = fault_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg      <= DEBOUNCE_SAMPLES_RST;
            active_level_reg <= ACTIVE_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_SAMPLES: samples_reg      <= cfg_wdata;
                CFG_ACTIVE_LEVEL:     active_level_reg <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            confirm_reg   <= '0;
            cancel_reg    <= '0;
            mode_reg      <= MODE_BOOTING;
            fault_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                v1_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= v1_reg;
            end
            if (s1_fire)
            begin
                confirm_reg <= confirm_next;
                cancel_reg  <= cancel_next;
                mode_reg    <= mode_next;
                fault_reg   <= fault_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= cmd.data;
            fold_reg <= fold_next;
        end
        if (s1_fire)
        begin
            out_reg <= out_next;
        end
    end

    // the fault flag never clears once set, short of a reset
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |=> fault_reg)
        else $error("read fault flag cleared");

    // a read error forces the fatal mode and the fault flag
    a_error_fatal: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && cmd_reg.opcode == OP_POLL && !cmd_reg.stop_request &&
         cmd_reg.read_error_code != ERR_NONE)
        |=> (mode_reg == MODE_FATAL && fault_reg))
        else $error("read error did not force fatal mode");

    // press events only come on clean running polls
    a_press_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.confirm_press || out_reg.cancel_press))
        |-> (out_reg.led_valid && out_reg.keep_running &&
             out_reg.error_code == ERR_NONE))
        else $error("press event on a non running beat");

    // led drive only on running polls
    a_led_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.led_valid) |-> out_reg.keep_running)
        else $error("led beat without running poll");

    // a full input stage behind a stalled result takes no new beat
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && out_valid_reg && !res.ready) |-> !cmd.ready)
        else $error("input stage overrun");

endmodule

// ----- tb/testbench.sv -----
// ============================================================================
// testbench
// Checks the dual button debounce and status blinker against a cycle-free
// behavioral predictor: a directed table of polls and mode changes, then
// random button sequences under several debounce and active level settings,
// with random stalls on both channels and one long result-side hold-off.
// ============================================================================
module testbench
    import dbsb_pkg::*;
();

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        cmd_beat_t beat;
        bit        typed;
        res_beat_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_wdata;

    dbsb_stream_if #(.payload_t(cmd_beat_t)) cmd_ch ();
    dbsb_stream_if #(.payload_t(res_beat_t)) res_ch ();

    dual_button_debounce_status_blinker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // predictor state and register copies
    logic [7:0] samples_needed = DEBOUNCE_SAMPLES_RST;
    logic       pressed_level  = ACTIVE_LEVEL_RST;
    db_state_t  confirm_button = '0;
    db_state_t  cancel_button  = '0;
    mode_t      led_mode       = MODE_BOOTING;
    logic       fault_latched  = 1'b0;

    res_beat_t  pending_status[$];
    stim_row_t  directed_rows[$];
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;
    bit         gaps_on        = 1'b1;
    bit         hold_request   = 1'b0;

    // random button sequence state
    logic        confirm_hold = 1'b0;
    logic        cancel_hold  = 1'b0;
    int          confirm_left = 0;
    int          cancel_left  = 0;
    logic [31:0] ms_clock     = 32'd0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // counter debouncer, returns the press event
    function automatic logic debounce_button(inout db_state_t st, input logic sample);
        if (sample != st.candidate)
        begin
            st.candidate = sample;
            st.count     = 8'd1;
            return 1'b0;
        end
        if (st.count < samples_needed)
            st.count = st.count + 8'd1;
        if (st.count == samples_needed && st.stable != sample)
        begin
            st.stable = sample;
            return sample;
        end
        return 1'b0;
    endfunction

    // blink pattern of each indicator mode
    function automatic logic blink_level(mode_t m, logic [31:0] t);
        logic [31:0] pos;
        case (m)
            MODE_READY:     return 1'b1;
            MODE_BOOTING:   return (t % 32'd1000) < 32'd250;
            MODE_EXECUTING: return (t % 32'd200) < 32'd100;
            MODE_DEGRADED:
            begin
                pos = t % 32'd2000;
                return pos < 32'd250 || (pos >= 32'd500 && pos < 32'd750);
            end
            MODE_FATAL:     return (t % 32'd500) < 32'd250;
            default:        return 1'b0;
        endcase
    endfunction

    // expected status beat for one command beat, advances predictor state
    function automatic res_beat_t predict_status(cmd_beat_t b);
        res_beat_t r;
        r = '0;
        if (b.opcode == OP_SET)
        begin
            if (b.new_mode > MODE_FATAL)
                r.error_code = ERR_INVALID_MODE;
            else
                led_mode = mode_t'(b.new_mode);
        end
        else if (!b.stop_request)
        begin
            r.keep_running = 1'b1;
            if (b.read_error_code != ERR_NONE)
            begin
                fault_latched = 1'b1;
                led_mode      = MODE_FATAL;
                r.error_code  = b.read_error_code;
            end
            else
            begin
                r.confirm_press = debounce_button(confirm_button,
                                                  b.confirm_level == pressed_level);
                r.cancel_press  = debounce_button(cancel_button,
                                                  b.cancel_level == pressed_level);
            end
            r.led_valid = 1'b1;
            r.led_on    = blink_level(led_mode, b.stamp_ms);
        end
        r.fault_seen = fault_latched;
        return r;
    endfunction

    function automatic cmd_beat_t poll_beat(bit stop, logic [3:0] rd_err, bit conf,
                                            bit canc, logic [31:0] t);
        cmd_beat_t b;
        b = '0;
        b.opcode          = OP_POLL;
        b.stop_request    = stop;
        b.read_error_code = rd_err;
        b.confirm_level   = conf;
        b.cancel_level    = canc;
        b.stamp_ms        = t;
        return b;
    endfunction

    function automatic cmd_beat_t set_beat(logic [2:0] m);
        cmd_beat_t b;
        b = '0;
        b.opcode   = OP_SET;
        b.new_mode = m;
        return b;
    endfunction

    function automatic res_beat_t status_beat(bit run, bit cp, bit xp, bit lv, bit lo,
                                              logic [3:0] err, bit fault);
        res_beat_t r;
        r.keep_running  = run;
        r.confirm_press = cp;
        r.cancel_press  = xp;
        r.led_valid     = lv;
        r.led_on        = lo;
        r.error_code    = err;
        r.fault_seen    = fault;
        return r;
    endfunction

    // idle length: mostly none, mostly short otherwise, sometimes long
    function automatic int pick_gap();
        if ($urandom_range(0, 2) != 0)
            return 0;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // offer one command beat, record its expectation once taken
    task automatic send_beat(cmd_beat_t b, bit typed, res_beat_t want);
        int        gap;
        res_beat_t predicted;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= b;
        do @(posedge clk); while (!cmd_ch.ready);
        predicted = predict_status(b);
        pending_status.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait for every expected status beat
    task automatic drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
    endtask

    // write both registers, block is idle
    task automatic configure(logic [7:0] samples, logic active);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_SAMPLES;
        cfg_wdata <= samples;
        @(negedge clk);
        cfg_index <= CFG_ACTIVE_LEVEL;
        cfg_wdata <= {7'd0, active};
        @(negedge clk);
        cfg_we <= 1'b0;
        samples_needed = samples;
        pressed_level  = active;
    endtask

    // held button level with occasional one-sample bounces
    task automatic next_level(inout logic lvl, inout int left, input int run_max);
        if (left == 0)
        begin
            lvl  = 1'($urandom_range(0, 1));
            left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, run_max);
        end
        left--;
    endtask

    task automatic random_beat(output cmd_beat_t b, input int run_max);
        int sel;
        b = '0;
        next_level(confirm_hold, confirm_left, run_max);
        next_level(cancel_hold, cancel_left, run_max);
        b.opcode        = OP_POLL;
        b.confirm_level = confirm_hold;
        b.cancel_level  = cancel_hold;
        b.new_mode      = 3'($urandom_range(0, 7));
        b.stamp_ms      = ($urandom_range(0, 9) == 0) ? $urandom : ms_clock;
        ms_clock        = ms_clock + $urandom_range(1, 97);
        sel = $urandom_range(0, 99);
        if (sel < 4)
        begin
            b.opcode          = OP_SET;
            b.stop_request    = 1'($urandom_range(0, 1));
            b.read_error_code = 4'($urandom_range(0, 15));
        end
        else if (sel < 8)
        begin
            b.stop_request    = 1'b1;
            b.read_error_code = 4'($urandom_range(0, 15));
        end
        else if (sel < 11)
            b.read_error_code = 4'($urandom_range(1, 15));
    endtask

    task automatic run_random(int n, int run_max);
        cmd_beat_t b;
        for (int k = 0; k < n; k++)
        begin
            random_beat(b, run_max);
            send_beat(b, 1'b0, '0);
        end
    endtask

    // status beat receiver with random stalls and one long hold-off
    initial
    begin
        int stall_left;
        int gap;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                gap = gaps_on ? pick_gap() : 0;
                if (gap > 0)
                begin
                    stall_left   = gap - 1;
                    res_ch.ready <= 1'b0;
                end
                else
                    res_ch.ready <= 1'b1;
            end
        end
    end

    // compare each status beat with the oldest expectation
    always @(posedge clk)
    begin
        res_beat_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_status.size() == 0)
                report_mismatch("status beat with nothing expected");
            else
            begin
                want = pending_status.pop_front();
                check_field("keep_running", 32'(res_ch.data.keep_running),
                            32'(want.keep_running));
                check_field("confirm_press", 32'(res_ch.data.confirm_press),
                            32'(want.confirm_press));
                check_field("cancel_press", 32'(res_ch.data.cancel_press),
                            32'(want.cancel_press));
                check_field("led_valid", 32'(res_ch.data.led_valid), 32'(want.led_valid));
                check_field("led_on", 32'(res_ch.data.led_on), 32'(want.led_on));
                check_field("error_code", 32'(res_ch.data.error_code),
                            32'(want.error_code));
                check_field("fault_seen", 32'(res_ch.data.fault_seen),
                            32'(want.fault_seen));
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("[dual_button_debounce_status_blinker] ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_DEBOUNCE_SAMPLES;
        cfg_wdata    = 8'd0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;

        // directed table, reset configuration
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 1, 1, 32'd0), 1'b1,
                                status_beat(1, 0, 0, 1, 1, ERR_NONE, 0)});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 1, 1, 32'd250), 1'b1,
                                status_beat(1, 0, 0, 1, 0, ERR_NONE, 0)});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 0, 32'd999), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{set_beat(MODE_READY), 1'b1,
                                status_beat(0, 0, 0, 0, 0, ERR_NONE, 0)});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 0, 32'hFFFF_FFFF), 1'b1,
                                status_beat(1, 0, 0, 1, 1, ERR_NONE, 0)});
        // both buttons held until stable
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 0, 32'd17), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 0, 32'd40), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 0, 32'd80), 1'b0, '0});
        // modes above fatal are rejected
        directed_rows.push_back(stim_row_t'{set_beat(3'd5), 1'b1,
                                status_beat(0, 0, 0, 0, 0, ERR_INVALID_MODE, 0)});
        directed_rows.push_back(stim_row_t'{set_beat(3'd7), 1'b1,
                                status_beat(0, 0, 0, 0, 0, ERR_INVALID_MODE, 0)});
        directed_rows.push_back(stim_row_t'{set_beat(MODE_EXECUTING), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 1, 32'd99), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 1, 32'd100), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{set_beat(MODE_DEGRADED), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 1, 32'hFFFF_FFFF), 1'b0,
                                '0});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 1, 32'd500), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 1, 32'd749), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 0, 1, 32'd750), 1'b0, '0});
        // stop request ignores everything else
        directed_rows.push_back(stim_row_t'{poll_beat(1, 4'd9, 1, 1, 32'd123), 1'b1,
                                status_beat(0, 0, 0, 0, 0, ERR_NONE, 0)});
        directed_rows.push_back(stim_row_t'{set_beat(MODE_FATAL), 1'b0, '0});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd0, 1, 1, 32'd249), 1'b0, '0});
        // read errors, the top code collides with the invalid mode code
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd14, 1, 1, 32'd0), 1'b1,
                                status_beat(1, 0, 0, 1, 1, 4'd14, 1)});
        directed_rows.push_back(stim_row_t'{poll_beat(0, 4'd15, 0, 0, 32'd250), 1'b1,
                                status_beat(1, 0, 0, 1, 0, 4'd15, 1)});
        directed_rows.push_back(stim_row_t'{set_beat(MODE_BOOTING), 1'b1,
                                status_beat(0, 0, 0, 0, 0, ERR_NONE, 1)});
        directed_rows.push_back(stim_row_t'{poll_beat(1, 4'd0, 0, 0, 32'd0), 1'b1,
                                status_beat(0, 0, 0, 0, 0, ERR_NONE, 1)});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        drain();

        // single sample debounce, active high, then a long result hold-off
        configure(8'd1, 1'b1);
        run_random(150, 4);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        run_random(60, 4);
        gaps_on = 1'b1;
        drain();

        // widest debounce window with long steady runs
        configure(8'd255, 1'b0);
        run_random(350, 320);
        drain();

        // window lowered under the running counts
        configure(8'd3, 1'b0);
        run_random(100, 8);
        drain();

        // zero samples never settles
        configure(8'd0, 1'b1);
        run_random(100, 10);
        drain();

        // no idling on either side, with a full pause in the middle
        configure(8'd2, 1'b0);
        gaps_on = 1'b0;
        run_random(75, 6);
        drain();
        run_random(75, 6);
        gaps_on = 1'b1;
        drain();

        // random window and level
        configure(8'($urandom_range(1, 12)), 1'($urandom_range(0, 1)));
        run_random(150, 16);
        drain();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[dual_button_debounce_status_blinker] OK");
        else
            $display("[dual_button_debounce_status_blinker] ERROR");
        $finish;
    end

endmodule

// ----- dual_button_debounce_status_blinker.f -----
hw/rtl/dbsb_pkg.sv
hw/rtl/dbsb_stream_if.sv
hw/rtl/dual_button_debounce_status_blinker.sv
tb/testbench.sv
